[design/open_addressing_hash_insert_macros.svh]
// ----------------------------------------------------------------------------
// open_addressing_hash_insert assertion macros
// Concurrent assertion shorthands, clocked on i_clk, off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef OPEN_ADDRESSING_HASH_INSERT_MACROS_SVH
`define OPEN_ADDRESSING_HASH_INSERT_MACROS_SVH

// same-cycle implication
`define OAHI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OAHI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/oahi_pkg.sv]
// ----------------------------------------------------------------------------
// oahi_pkg
// Types and constants shared by the open-addressed hash insert block.
// ----------------------------------------------------------------------------
`default_nettype none

package oahi_pkg;

    localparam int KEY_W       = 31;
    localparam int SIZE_W      = 7;
    localparam int SLOT_W      = 6;
    localparam int MODE_W      = 2;
    localparam int DIGIT_W     = 4;
    localparam int DIGITS      = 8;
    localparam int DIGIT_CNT_W = 3;
    localparam int SHIFT_W     = DIGIT_W * DIGITS;

    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUAD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd2;

    localparam logic [SIZE_W-1:0] DH_PRIME = 7'd7;

    localparam logic CFG_PROBE_MODE = 1'b0;
    localparam logic CFG_TABLE_SIZE = 1'b1;

    localparam logic [MODE_W-1:0] MODE_RESET = MODE_LINEAR;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_RED,
        S_PROBE
    } t_state;

    typedef struct packed {
        logic              en;
        logic [SIZE_W-1:0] idx;
        logic [KEY_W-1:0]  key;
    } t_store_wr;

endpackage

`default_nettype wire

[design/oahi_modunit.sv]
// ----------------------------------------------------------------------------
// oahi_modunit
// Restoring remainder step: folds one 4-bit digit into a running remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module oahi_modunit (
    input  wire logic [oahi_pkg::SIZE_W-1:0]  i_rem,
    input  wire logic [oahi_pkg::DIGIT_W-1:0] i_digit,
    input  wire logic [oahi_pkg::SIZE_W-1:0]  i_mod,
    output logic      [oahi_pkg::SIZE_W-1:0]  o_rem
);

    always_comb begin
        logic [oahi_pkg::SIZE_W-1:0] v_rem;
        logic [oahi_pkg::SIZE_W:0]   v_trial;
        v_rem = i_rem;
        // remainder stays below the modulus, so one subtract per bit suffices
        for (int k = oahi_pkg::DIGIT_W - 1; k >= 0; k--) begin
            v_trial = {v_rem, i_digit[k]};
            if (v_trial >= {1'b0, i_mod}) begin
                v_trial = v_trial - {1'b0, i_mod};
            end
            v_rem = v_trial[oahi_pkg::SIZE_W-1:0];
        end
        o_rem = v_rem;
    end

endmodule

`default_nettype wire

[design/oahi_store.sv]
// ----------------------------------------------------------------------------
// oahi_store
// Slot occupancy flags, cleared by reset, and the key store behind them.
// ----------------------------------------------------------------------------
`default_nettype none

module oahi_store #(
    parameter int DEPTH = 64,
    parameter int IW    = 6
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire oahi_pkg::t_store_wr i_wr,
    input  wire logic [IW-1:0]       i_rd_idx,
    output logic                     o_used
);

    logic [DEPTH-1:0]            r_used;
    logic [oahi_pkg::KEY_W-1:0]  r_key_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_wr.en) begin
            r_used[i_wr.idx[IW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_key_mem[i_wr.idx[IW-1:0]] <= i_wr.key;
        end
    end

    assign o_used = r_used[i_rd_idx];

endmodule

`default_nettype wire

[design/open_addressing_hash_insert.sv]
// ----------------------------------------------------------------------------
// open_addressing_hash_insert
// Inserts keys into an open-addressed table with linear, quadratic or
// double-hashing probes; reports slot, occupied slots passed and a full flag.
// ----------------------------------------------------------------------------
// channel   dir  handshake                 payload
// item      in   start high, busy low      i_key
// result    out  o_strobe, one cycle       o_slot, o_probes, o_full_res
// config    in   i_cfg_we                  i_cfg_idx, i_cfg_data
//
// Each item passes S_DIV, where both remainder units fold one 4-bit key digit
// per cycle, most significant first; then S_RED, which brings the step below
// the size (needed only when the size does not exceed the step); then S_PROBE,
// one slot-flag lookup per probe until a free slot is found or the table is
// full. busy is low again in the strobe cycle.
// Reset clears all slot flags at once; probe_mode goes to linear, size to 64.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module open_addressing_hash_insert #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [oahi_pkg::KEY_W-1:0]       i_key,
    output logic                                  o_strobe,
    output logic      [oahi_pkg::SLOT_W-1:0]      o_slot,
    output logic      [oahi_pkg::SIZE_W-1:0]      o_probes,
    output logic                                  o_full_res,
    input  wire logic                             i_cfg_we,
    input  wire logic                             i_cfg_idx,
    input  wire logic [oahi_pkg::SIZE_W-1:0]      i_cfg_data
);

    // table_size is 7 bits, so no more than 127 slots are ever reachable
    localparam int USED_DEPTH = (TABLE_DEPTH < 128) ? TABLE_DEPTH : 128;
    localparam int IW         = $clog2(USED_DEPTH);
    localparam logic [oahi_pkg::SIZE_W-1:0] SIZE_CAP =
        oahi_pkg::SIZE_W'((USED_DEPTH > 127) ? 127 : USED_DEPTH);

    localparam int SW = oahi_pkg::SIZE_W;

    oahi_pkg::t_state r_state, n_state;

    logic [oahi_pkg::MODE_W-1:0]      r_mode;
    logic [SW-1:0]                    r_table_size;

    logic [oahi_pkg::SHIFT_W-1:0]     r_shift, n_shift;
    logic [oahi_pkg::DIGIT_CNT_W-1:0] r_cnt, n_cnt;
    logic [SW-1:0]                    r_rem, n_rem;
    logic [SW-1:0]                    r_rem7, n_rem7;
    logic [SW-1:0]                    r_size, n_size;
    logic [oahi_pkg::KEY_W-1:0]       r_key, n_key;
    logic [SW-1:0]                    r_inc, n_inc;
    logic [SW-1:0]                    r_idx, n_idx;
    logic [SW-1:0]                    r_i, n_i;
    logic                             r_strobe, n_strobe;
    logic [oahi_pkg::SLOT_W-1:0]      r_slot, n_slot;
    logic [SW-1:0]                    r_probes, n_probes;
    logic                             r_full, n_full;

    logic [SW-1:0]        eff_size;
    logic [SW-1:0]        div_rem;
    logic [SW-1:0]        div_rem7;
    logic [SW:0]          idx_sum;
    logic [SW-1:0]        idx_next;
    logic [SW:0]          inc_sum;
    logic [SW-1:0]        inc_next;
    logic                 slot_used;
    oahi_pkg::t_store_wr  store_wr;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= oahi_pkg::MODE_RESET;
            r_table_size <= oahi_pkg::SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                oahi_pkg::CFG_PROBE_MODE: r_mode       <= i_cfg_data[oahi_pkg::MODE_W-1:0];
                oahi_pkg::CFG_TABLE_SIZE: r_table_size <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        if (r_table_size == '0) begin
            eff_size = SW'(1);
        end else if (r_table_size > SIZE_CAP) begin
            eff_size = SIZE_CAP;
        end else begin
            eff_size = r_table_size;
        end
    end

    // home slot and key mod 7, one digit per cycle, most significant first
    oahi_modunit u_mod_home (
        .i_rem   (r_rem),
        .i_digit (r_shift[oahi_pkg::SHIFT_W-1 -: oahi_pkg::DIGIT_W]),
        .i_mod   (r_size),
        .o_rem   (div_rem)
    );

    oahi_modunit u_mod_prime (
        .i_rem   (r_rem7),
        .i_digit (r_shift[oahi_pkg::SHIFT_W-1 -: oahi_pkg::DIGIT_W]),
        .i_mod   (oahi_pkg::DH_PRIME),
        .o_rem   (div_rem7)
    );

    // both operands stay below the size, so one subtract wraps the sum
    assign idx_sum  = {1'b0, r_idx} + {1'b0, r_inc};
    assign idx_next = (idx_sum >= {1'b0, r_size}) ? SW'(idx_sum - {1'b0, r_size})
                                                  : idx_sum[SW-1:0];
    assign inc_sum  = {1'b0, r_inc} + (SW+1)'(2);
    assign inc_next = (inc_sum >= {1'b0, r_size}) ? SW'(inc_sum - {1'b0, r_size})
                                                  : inc_sum[SW-1:0];

    oahi_store #(
        .DEPTH (USED_DEPTH),
        .IW    (IW)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (store_wr),
        .i_rd_idx (r_idx[IW-1:0]),
        .o_used   (slot_used)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= oahi_pkg::S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift  <= n_shift;
        r_cnt    <= n_cnt;
        r_rem    <= n_rem;
        r_rem7   <= n_rem7;
        r_size   <= n_size;
        r_key    <= n_key;
        r_inc    <= n_inc;
        r_idx    <= n_idx;
        r_i      <= n_i;
        r_slot   <= n_slot;
        r_probes <= n_probes;
        r_full   <= n_full;
    end

    always_comb begin
        n_state  = r_state;
        n_shift  = r_shift;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_rem7   = r_rem7;
        n_size   = r_size;
        n_key    = r_key;
        n_inc    = r_inc;
        n_idx    = r_idx;
        n_i      = r_i;
        n_strobe = 1'b0;
        n_slot   = r_slot;
        n_probes = r_probes;
        n_full   = r_full;
        store_wr = '{en: 1'b0, idx: r_idx, key: r_key};

        unique case (r_state)
            oahi_pkg::S_IDLE: begin
                if (start) begin
                    n_shift = {1'b0, i_key};
                    n_key   = i_key;
                    n_cnt   = '0;
                    n_rem   = '0;
                    n_rem7  = '0;
                    n_size  = eff_size;
                    n_state = oahi_pkg::S_DIV;
                end
            end
            oahi_pkg::S_DIV: begin
                n_shift = r_shift << oahi_pkg::DIGIT_W;
                n_rem   = div_rem;
                n_rem7  = div_rem7;
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == oahi_pkg::DIGIT_CNT_W'(oahi_pkg::DIGITS - 1)) begin
                    n_idx   = div_rem;
                    n_i     = '0;
                    n_state = oahi_pkg::S_RED;
                    if (r_mode == oahi_pkg::MODE_DOUBLE) begin
                        n_inc = oahi_pkg::DH_PRIME - div_rem7;
                    end else begin
                        n_inc = SW'(1);
                    end
                end
            end
            oahi_pkg::S_RED: begin
                // bring the step below the size
                if (r_inc >= r_size) begin
                    n_inc = r_inc - r_size;
                end else begin
                    n_state = oahi_pkg::S_PROBE;
                end
            end
            oahi_pkg::S_PROBE: begin
                if (!slot_used) begin
                    store_wr.en = 1'b1;
                    n_strobe    = 1'b1;
                    n_slot      = r_idx[oahi_pkg::SLOT_W-1:0];
                    n_probes    = r_i;
                    n_full      = 1'b0;
                    n_state     = oahi_pkg::S_IDLE;
                end else if (r_i + SW'(1) == r_size) begin
                    // every probe hit an occupied slot: drop the key
                    n_strobe = 1'b1;
                    n_slot   = '0;
                    n_probes = r_size;
                    n_full   = 1'b1;
                    n_state  = oahi_pkg::S_IDLE;
                end else begin
                    n_i   = r_i + SW'(1);
                    n_idx = idx_next;
                    // quadratic offsets grow by 2i+1
                    if (r_mode == oahi_pkg::MODE_QUAD) begin
                        n_inc = inc_next;
                    end
                end
            end
            default: begin
                n_state = oahi_pkg::S_IDLE;
            end
        endcase
    end

    assign busy       = (r_state != oahi_pkg::S_IDLE);
    assign o_strobe   = r_strobe;
    assign o_slot     = r_slot;
    assign o_probes   = r_probes;
    assign o_full_res = r_full;

endmodule

`default_nettype wire

[design/oahi_checker.sv]
// ----------------------------------------------------------------------------
// oahi_checker
// Port-level checks on the insert block's command and result timing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "open_addressing_hash_insert_macros.svh"

module oahi_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             start,
    input wire logic                             busy,
    input wire logic                             o_strobe,
    input wire logic [oahi_pkg::SLOT_W-1:0]      o_slot,
    input wire logic                             o_full_res
);

    `OAHI_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `OAHI_ASSERT_IMP(a_strobe_idle, o_strobe, !busy, "result shown while still busy")
    `OAHI_ASSERT_NXT(a_strobe_single, o_strobe, !o_strobe, "result strobe held past one cycle")
    `OAHI_ASSERT_IMP(a_full_slot, o_strobe && o_full_res, o_slot == '0, "full result with slot")
    `OAHI_ASSERT_NXT(a_busy_result, busy && !o_strobe, busy || o_strobe, "busy ended w/o result")

endmodule

bind open_addressing_hash_insert oahi_checker u_oahi_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_strobe   (o_strobe),
    .o_slot     (o_slot),
    .o_full_res (o_full_res)
);

`default_nettype wire
